// ----- rtl/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants of the bitmap frame allocator
// Map geometry, item formats, controller command and status groups, and
// find-first helpers.
// ----------------------------------------------------------------------------
package bfa_pkg;

	localparam int FRAMES      = 65536;
	localparam int WORD_BITS   = 32;
	localparam int MAP_WORDS   = FRAMES / WORD_BITS;
	localparam int SUM_WORDS   = MAP_WORDS / WORD_BITS;
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int MAP_AW      = $clog2(MAP_WORDS);
	localparam int SUM_AW      = $clog2(SUM_WORDS);
	localparam int FRAME_W     = 16;
	localparam int TOTAL_W     = 17;
	localparam int TALLY_W     = 17;
	localparam int ADDR_W      = 28;
	localparam int PAGE_SHIFT  = 12;

	localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(65536);
	localparam logic [TALLY_W-1:0] TALLY_MAX   = {TALLY_W{1'b1}};

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_AVAIL   = 2'd2,
		CMD_RESERVE = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [FRAME_W-1:0] frame;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  frame_address;
		logic               out_of_memory;
		logic [TALLY_W-1:0] free_count;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic clear_step;
		logic look_alloc;
		logic look_other;
		logic oom_load;
		logic amap;
		logic upd;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic is_alloc;
		logic top_empty;
		logic slot_free;
	} ctrl_stat_t;

	function automatic logic [BIT_W-1:0] ffs_word(input logic [WORD_BITS-1:0] v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) idx = BIT_W'(i);
		end
		return idx;
	endfunction

	function automatic logic [SUM_AW-1:0] ffs_top(input logic [SUM_WORDS-1:0] v);
		logic [SUM_AW-1:0] idx;
		idx = '0;
		for (int i = SUM_WORDS - 1; i >= 0; i--) begin
			if (v[i]) idx = SUM_AW'(i);
		end
		return idx;
	endfunction

endpackage

// ----- rtl/bitmap_frame_allocator_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top: first-fit page frame allocator
// After reset the block runs a pass that sets every bitmap word to used and
// stalls input until that pass ends; configuration writes are taken
// throughout. Each item then steps through accept, lookup and update; alloc
// adds a bitmap word fetch before update, and an alloc with no free frame
// anywhere answers right after lookup. The steps are set by the lookup
// chain through the nonzero-summary register, the summary memory and the
// bitmap memory, the memories each read through one registered port. Alloc
// returns the lowest free frame below the frame limit register times 4096,
// or zero with out_of_memory; free, make-available and reserve flip one
// frame's bit when its state allows. free_count is the tally after the
// item. A new item is accepted while the previous result still waits on
// out_stall; it then holds in lookup until that result leaves.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top import bfa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data,
	input  logic               cfg_we,
	input  logic [TOTAL_W-1:0] cfg_data
);

	ctrl_cmd_t  ctl;
	ctrl_stat_t stat;

	bfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	bfa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- rtl/bfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfa_ctrl: allocator sequencer
// Runs the map clearing pass after reset, then steps each item through
// lookup, word fetch (alloc only) and update, or ends an empty-map alloc at lookup.
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  ctl
);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_LOOK  = 5'b00100,
		ST_AMAP  = 5'b01000,
		ST_UPD   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		case (state_q)
			ST_CLEAR: begin
				ctl.clear_step = 1'b1;
				if (stat.clear_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load_item = 1'b1;
					state_nxt     = ST_LOOK;
				end
			end
			ST_LOOK: begin
				// hold here until the result register can take the next result
				if (stat.slot_free) begin
					if (!stat.is_alloc) begin
						ctl.look_other = 1'b1;
						state_nxt      = ST_UPD;
					end else if (stat.top_empty) begin
						ctl.oom_load = 1'b1;
						state_nxt    = ST_IDLE;
					end else begin
						ctl.look_alloc = 1'b1;
						state_nxt      = ST_AMAP;
					end
				end
			end
			ST_AMAP: begin
				ctl.amap  = 1'b1;
				state_nxt = ST_UPD;
			end
			ST_UPD: begin
				ctl.upd   = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// ----- rtl/bfa_dp.sv -----
// ----------------------------------------------------------------------------
// bfa_dp: allocator datapath
// Frame bitmap memory, a summary memory of words with a free bit, a
// register of summary words that are nonzero, the free tally and the
// result register.
// ----------------------------------------------------------------------------
module bfa_dp import bfa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          ctl,
	output ctrl_stat_t         stat,
	input  in_item_t           in_data,
	input  logic               cfg_we,
	input  logic [TOTAL_W-1:0] cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data
);

	logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [WORD_BITS-1:0] sum_mem [SUM_WORDS];

	cmd_t                 item_cmd_q;
	logic [FRAME_W-1:0]   item_frame_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [TALLY_W-1:0]   tally_q;
	logic [SUM_WORDS-1:0] top_q;
	logic [MAP_AW-1:0]    clr_q;
	logic [MAP_AW-1:0]    widx_q;
	logic [WORD_BITS-1:0] map_rd_q;
	logic [WORD_BITS-1:0] sum_rd_q;
	logic                 sum_vld_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic [WORD_BITS-1:0] sum_eff;
	logic                 map_re;
	logic [MAP_AW-1:0]    map_raddr;
	logic                 sum_re;
	logic [SUM_AW-1:0]    sum_raddr;
	logic                 is_alloc;
	logic [BIT_W-1:0]     upd_bit;
	logic [MAP_AW-1:0]    upd_widx;
	logic [FRAME_W-1:0]   upd_frame;
	logic                 bit_used;
	logic [TOTAL_W-1:0]   limit;
	logic                 fits;
	logic                 set_used;
	logic                 upd_change;
	logic [WORD_BITS-1:0] bit_mask;
	logic [WORD_BITS-1:0] new_word;
	logic [SUM_AW-1:0]    sum_idx;
	logic [BIT_W-1:0]     sum_bit;
	logic [WORD_BITS-1:0] sum_mask;
	logic [WORD_BITS-1:0] new_sum;
	logic [TALLY_W-1:0]   tally_nxt;
	logic                 map_we;
	logic [MAP_AW-1:0]    map_waddr;
	logic [WORD_BITS-1:0] map_wdata;

	// summary words never written read as zero through their top bit
	assign sum_eff  = sum_vld_q ? sum_rd_q : '0;
	assign is_alloc = (item_cmd_q == CMD_ALLOC);

	// summary index chosen during lookup, kept in the high bits of widx_q
	assign map_re    = ctl.look_other | ctl.amap;
	assign map_raddr = ctl.look_other ? item_frame_q[FRAME_W-1:BIT_W]
	                                  : {widx_q[MAP_AW-1 -: SUM_AW], ffs_word(sum_eff)};
	assign sum_re    = ctl.look_alloc | ctl.look_other;
	assign sum_raddr = ctl.look_alloc ? ffs_top(top_q) : item_frame_q[FRAME_W-1 -: SUM_AW];

	assign upd_bit   = is_alloc ? ffs_word(~map_rd_q) : item_frame_q[BIT_W-1:0];
	assign upd_widx  = is_alloc ? widx_q : item_frame_q[FRAME_W-1:BIT_W];
	assign upd_frame = {upd_widx, upd_bit};
	assign bit_used  = map_rd_q[upd_bit];
	assign limit     = (total_q < TOTAL_W'(FRAMES)) ? total_q : TOTAL_W'(FRAMES);
	assign fits      = ({1'b0, upd_frame} < limit);
	assign set_used  = is_alloc | (item_cmd_q == CMD_RESERVE);
	assign upd_change = is_alloc ? fits : (set_used ? !bit_used : bit_used);

	assign bit_mask = WORD_BITS'(1) << upd_bit;
	assign new_word = set_used ? (map_rd_q | bit_mask) : (map_rd_q & ~bit_mask);
	assign sum_idx  = upd_widx[MAP_AW-1 -: SUM_AW];
	assign sum_bit  = upd_widx[BIT_W-1:0];
	assign sum_mask = WORD_BITS'(1) << sum_bit;
	assign new_sum  = (sum_eff & ~sum_mask) | ((~&new_word) ? sum_mask : '0);

	always_comb begin
		tally_nxt = tally_q;
		if (ctl.upd && upd_change) begin
			if (set_used) begin
				if (tally_q != '0) tally_nxt = tally_q - TALLY_W'(1);
			end else begin
				if (tally_q != TALLY_MAX) tally_nxt = tally_q + TALLY_W'(1);
			end
		end
	end

	assign map_we    = ctl.clear_step | (ctl.upd & upd_change);
	assign map_waddr = ctl.clear_step ? clr_q : upd_widx;
	assign map_wdata = ctl.clear_step ? '1 : new_word;

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_waddr] <= map_wdata;
		if (map_re) map_rd_q <= map_mem[map_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.upd && upd_change) sum_mem[sum_idx] <= new_sum;
		if (sum_re) sum_rd_q <= sum_mem[sum_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			item_cmd_q   <= in_data.cmd;
			item_frame_q <= in_data.frame;
		end
		if (ctl.look_alloc) widx_q <= {ffs_top(top_q), BIT_W'(0)};
		if (ctl.amap) widx_q <= map_raddr;
		if (ctl.upd) begin
			out_q.frame_address <= (is_alloc && fits)
				? ADDR_W'({upd_frame, {PAGE_SHIFT{1'b0}}}) : '0;
			out_q.out_of_memory <= is_alloc && !fits;
			out_q.free_count    <= tally_nxt;
		end else if (ctl.oom_load) begin
			out_q.frame_address <= '0;
			out_q.out_of_memory <= 1'b1;
			out_q.free_count    <= tally_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= TOTAL_RESET;
			tally_q     <= '0;
			top_q       <= '0;
			clr_q       <= '0;
			sum_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) total_q <= cfg_data;
			tally_q <= tally_nxt;
			if (ctl.clear_step) clr_q <= clr_q + MAP_AW'(1);
			if (sum_re) sum_vld_q <= top_q[sum_raddr];
			if (ctl.upd && upd_change) top_q[sum_idx] <= |new_sum;
			if (ctl.upd || ctl.oom_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.clear_last = (clr_q == MAP_AW'(MAP_WORDS - 1));
	assign stat.is_alloc   = is_alloc;
	assign stat.top_empty  = (top_q == '0);
	assign stat.slot_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_upd_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd |=> out_valid_q)
		else $error("update did not load a result");

	a_oom_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.out_of_memory |-> out_q.frame_address == '0)
		else $error("out of memory result carries an address");

	a_tally_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tally_q <= TALLY_W'(FRAMES))
		else $error("free tally above frame count");

	a_no_change_keeps_tally: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd && !upd_change |=> $stable(tally_q))
		else $error("tally moved on an update that changed nothing");

endmodule

// ----- verif/tb_bitmap_frame_allocator_top.sv -----
// ----------------------------------------------------------------------------
// tb_bitmap_frame_allocator_top: self-checking bench for the frame allocator
// Keeps a bit-accurate copy of the used/free map, the free tally and the
// search limit, predicts each result as items are accepted and compares the
// results field by field. Directed corner cases come first. Then phases of
// region bring-up followed by mixed alloc/free/avail/reserve traffic, under several
// search limits, with random gaps on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator_top import bfa_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 8;
	localparam int PHASE_ITEMS  = 190;
	localparam int IDLE_PCT     = 24;

	// bit-accurate shadow of the allocator plus the results still owed
	class frame_ledger;
		bit [WORD_BITS-1:0] map_words [MAP_WORDS];
		bit [TALLY_W-1:0]   tally;
		bit [TOTAL_W-1:0]   limit_reg;
		out_item_t          owed_results [$];
		int                 mismatches;

		function new();
			foreach (map_words[w]) map_words[w] = '1;
			tally      = '0;
			limit_reg  = TOTAL_RESET;
			mismatches = 0;
		endfunction

		function void flag(string what, longint unsigned want, longint unsigned seen);
			mismatches++;
			if (mismatches <= 10)
				$display("frame allocator: %s expected %0h got %0h", what, want, seen);
		endfunction

		function void note_request(in_item_t it);
			out_item_t r;
			int        span;
			int        f;
			bit        hit;
			r   = '0;
			hit = 1'b0;
			if (it.cmd == CMD_ALLOC) begin
				span = (limit_reg < FRAMES) ? int'(limit_reg) : FRAMES;
				for (int w = 0; w < MAP_WORDS && !hit && w * WORD_BITS < span; w++) begin
					if (map_words[w] != '1) begin
						for (int b = 0; b < WORD_BITS && !hit; b++) begin
							f = w * WORD_BITS + b;
							if (f < span && !map_words[w][b]) begin
								hit = 1'b1;
								map_words[w][b] = 1'b1;
								if (tally != '0) tally--;
								r.frame_address = ADDR_W'(f) << PAGE_SHIFT;
							end
						end
					end
				end
				r.out_of_memory = !hit;
			end else begin
				f = int'(it.frame);
				if (it.cmd == CMD_FREE || it.cmd == CMD_AVAIL) begin
					if (map_words[f / WORD_BITS][f % WORD_BITS]) begin
						map_words[f / WORD_BITS][f % WORD_BITS] = 1'b0;
						if (tally != TALLY_MAX) tally++;
					end
				end else if (!map_words[f / WORD_BITS][f % WORD_BITS]) begin
					map_words[f / WORD_BITS][f % WORD_BITS] = 1'b1;
					if (tally != '0) tally--;
				end
			end
			r.free_count = tally;
			owed_results.push_back(r);
		endfunction

		function void check_response(out_item_t got);
			out_item_t want;
			if (owed_results.size() == 0) begin
				flag("no result pending, frame_address", 0, got.frame_address);
				return;
			end
			want = owed_results.pop_front();
			if (got.frame_address != want.frame_address)
				flag("frame_address", want.frame_address, got.frame_address);
			if (got.out_of_memory != want.out_of_memory)
				flag("out_of_memory", want.out_of_memory, got.out_of_memory);
			if (got.free_count != want.free_count)
				flag("free_count", want.free_count, got.free_count);
		endfunction
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	in_item_t           in_data   = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_item_t          out_data;
	logic               cfg_we    = 1'b0;
	logic [TOTAL_W-1:0] cfg_data  = '0;

	frame_ledger ledger = new();
	int unsigned cycle_count = 0;
	int          hold_left   = 0;
	bit          hold_req    = 1'b0;
	bit          steady      = 1'b0;

	bitmap_frame_allocator_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) ledger.note_request(in_data);
			if (out_valid && !out_stall) ledger.check_response(out_data);
		end
	end

	// output side pacing, with one long hold-off on request
	always @(negedge clk) begin : rx_pace
		bit s;
		if (hold_left > 0) begin
			s = 1'b1;
			hold_left--;
		end else if (hold_req) begin
			s = 1'b1;
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end else begin
			s = !steady && ($urandom_range(99) < IDLE_PCT);
		end
		out_stall <= s;
	end

	task automatic issue(cmd_t c, logic [FRAME_W-1:0] f);
		in_item_t it;
		it.cmd   = c;
		it.frame = f;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (ledger.owed_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_frame_limit(logic [TOTAL_W-1:0] v);
		settle();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		ledger.limit_reg = v;
	endtask

	task automatic run_phase(logic [TOTAL_W-1:0] frames, bit high_base, bit pressure);
		int   span;
		int   base;
		int   bring_up;
		int   r;
		cmd_t c;
		logic [FRAME_W-1:0] f;
		write_frame_limit(frames);
		if (pressure) hold_req = 1'b1;
		span     = $urandom_range(32, 256);
		base     = high_base ? $urandom_range(0, 65535 - span) : 0;
		bring_up = $urandom_range(16, span);
		// hand a region to the allocator one frame per item
		for (int i = 0; i < bring_up; i++) issue(CMD_AVAIL, FRAME_W'(base + i));
		for (int i = bring_up; i < PHASE_ITEMS; i++) begin
			r = $urandom_range(99);
			if (r < 35)      c = CMD_ALLOC;
			else if (r < 60) c = CMD_FREE;
			else if (r < 85) c = CMD_AVAIL;
			else             c = CMD_RESERVE;
			if ($urandom_range(99) < 80) f = FRAME_W'(base + $urandom_range(0, span - 1));
			else                         f = FRAME_W'($urandom_range(0, 65535));
			issue(c, f);
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		write_frame_limit(TOTAL_RESET);

		// everything starts out used
		issue(CMD_ALLOC, 16'h0000);
		issue(CMD_RESERVE, 16'h0000);
		issue(CMD_FREE, 16'hFFFF);
		issue(CMD_FREE, 16'hFFFF);
		issue(CMD_AVAIL, 16'hFFFF);
		issue(CMD_ALLOC, 16'h1234);
		issue(CMD_ALLOC, 16'hFFFF);
		issue(CMD_AVAIL, 16'h0000);
		issue(CMD_AVAIL, 16'h0000);
		issue(CMD_RESERVE, 16'h0000);
		issue(CMD_RESERVE, 16'h0000);
		issue(CMD_AVAIL, 16'h5555);
		issue(CMD_AVAIL, 16'hAAAA);
		issue(CMD_FREE, 16'h00FF);
		issue(CMD_ALLOC, 16'h0000);
		issue(CMD_ALLOC, 16'h0000);
		issue(CMD_ALLOC, 16'h0000);
		issue(CMD_ALLOC, 16'h0000);

		// search limit edges: top frame just out of reach, clipped to the map, then zero
		write_frame_limit(TOTAL_W'(65535));
		issue(CMD_AVAIL, 16'hFFFF);
		issue(CMD_ALLOC, 16'h0000);
		write_frame_limit(TALLY_MAX);
		issue(CMD_ALLOC, 16'h0000);
		write_frame_limit('0);
		issue(CMD_AVAIL, 16'h0003);
		issue(CMD_ALLOC, 16'h0000);

		steady = 1'b1;
		run_phase(TOTAL_RESET, 1'b0, 1'b0);
		steady = 1'b0;
		run_phase(TALLY_MAX, 1'b0, 1'b0);
		run_phase(TOTAL_W'($urandom_range(8, 300)), 1'b0, 1'b1);
		run_phase(TOTAL_W'($urandom_range(0, 131071)), 1'b1, 1'b0);
		run_phase(TOTAL_W'(1), 1'b0, 1'b0);
		run_phase(TOTAL_W'(65535), 1'b1, 1'b0);
		run_phase(TOTAL_W'(64), 1'b0, 1'b0);

		settle();
		repeat (10) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.owed_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
